FILE: rtl/jitter_entropy_conditioner_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the jitter entropy conditioner
// Clocked, reset-qualified property checks shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef JITTER_ENTROPY_CONDITIONER_CORE_DEFINES_SVH
`define JITTER_ENTROPY_CONDITIONER_CORE_DEFINES_SVH

// Check a property on every rising clock edge outside reset
`define JEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check an implication whose consequent must hold in the next cycle, outside reset
`define JEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/jec_pkg.sv
// ----------------------------------------------------------------------------
// jec_pkg
// Types and constants of the jitter entropy conditioner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jec_pkg;

  // Mixing multipliers and pool rotation
  localparam logic [63:0] MIX_MUL_A   = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_B   = 64'hBF58_476D_1CE4_E5B9;
  localparam int unsigned POOL_ROTATE = 7;
  localparam int unsigned PRE_SHIFT   = 4;
  localparam int unsigned MID_SHIFT   = 17;
  localparam int unsigned POST_SHIFT  = 31;

  // Configuration register indexes
  localparam logic [1:0] CFG_FOLD_ITERATIONS   = 2'd0;
  localparam logic [1:0] CFG_SAMPLES_PER_ROUND = 2'd1;
  localparam logic [1:0] CFG_NON_ADVANCE_LIMIT = 2'd2;

  // Configuration reset values
  localparam logic [7:0] RST_FOLD_ITERATIONS   = 8'd128;
  localparam logic [7:0] RST_SAMPLES_PER_ROUND = 8'd64;
  localparam logic [7:0] RST_NON_ADVANCE_LIMIT = 8'd10;

  // Multiplier phases: low x low, high x low, low x high
  localparam logic [1:0] PH_LL = 2'd0;
  localparam logic [1:0] PH_HL = 2'd1;
  localparam logic [1:0] PH_LH = 2'd2;

  typedef enum logic [1:0] {
    ST_FOLDED    = 2'd0,
    ST_SKIPPED   = 2'd1,
    ST_ABORTED   = 2'd2,
    ST_EXTRACTED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_PRE    = 2'd1,
    S_MUL    = 2'd2,
    S_FINISH = 2'd3
  } state_e;

endpackage

FILE: rtl/jitter_entropy_conditioner_core.sv
// Extract and non-advancing samples go from accept to the finish step, which registers
// the result once the output slot is free. Folded samples first run fold_iterations
// iterations of a xorshift and two 64-bit multiplies on one shared 32x32 multiplier.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset (rst_ni low, asynchronous): pool, round position and run count clear, and the
// registers return to fold_iterations 128, samples_per_round 64, non_advance_limit 10.
// ----------------------------------------------------------------------------
// jitter_entropy_conditioner_core
// Folds timer deltas into a 64-bit entropy pool with an iterative mixer, and extracts and reseeds the pool on request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "jitter_entropy_conditioner_core_defines.svh"

module jitter_entropy_conditioner_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_wdata_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [63:0] time_before_i,
  input  logic [63:0] time_after_i,
  input  logic [63:0] reseed_value_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] pool_value_o,
  output logic [1:0]  status_o,
  output logic        round_done_o
);

  // Configuration registers
  logic [7:0] fold_iter_q, spr_q, limit_q;

  // Control state
  jec_pkg::state_e  state_q, state_d;
  jec_pkg::status_e kind_q, kind_d;
  logic [7:0]  iter_q, iter_d;
  logic [1:0]  ph_q, ph_d;
  logic        sel_b_q, sel_b_d;
  logic [63:0] pool_q, pool_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  run_q, run_d;

  // Datapath
  logic [63:0] x_q, x_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] reseed_q, reseed_d;

  // Output register
  logic        out_valid_q, out_valid_d;
  logic [63:0] out_pool_q, out_pool_d;
  jec_pkg::status_e out_status_q, out_status_d;
  logic        out_done_q, out_done_d;

  logic        in_acc, out_free;
  logic [63:0] konst, prod, p_full, mixed, pool_x;
  logic [31:0] mul_a, mul_b, p_hi;
  logic [8:0]  next_pos;
  logic [7:0]  run_inc;
  logic        abort;
  logic        round_end;

  assign in_stall_o   = (state_q != jec_pkg::S_IDLE);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign out_valid_o  = out_valid_q;
  assign pool_value_o = out_pool_q;
  assign status_o     = out_status_q;
  assign round_done_o = out_done_q;

  // Select multiplier operands for the current phase
  assign konst = sel_b_q ? jec_pkg::MIX_MUL_B : jec_pkg::MIX_MUL_A;
  always_comb begin
    case (ph_q)
      jec_pkg::PH_LL: begin
        mul_a = x_q[31:0];
        mul_b = konst[31:0];
      end
      jec_pkg::PH_HL: begin
        mul_a = x_q[63:32];
        mul_b = konst[31:0];
      end
      default: begin
        mul_a = x_q[31:0];
        mul_b = konst[63:32];
      end
    endcase
  end

  // Shared 32x32 multiplier
  assign prod = {32'd0, mul_a} * {32'd0, mul_b};

  // Close the product and apply the trailing xorshift
  assign p_hi   = acc_q[63:32] + prod[31:0];
  assign p_full = {p_hi, acc_q[31:0]};
  assign mixed  = sel_b_q ? (p_full ^ (p_full >> jec_pkg::POST_SHIFT))
                          : (p_full ^ (p_full >> jec_pkg::MID_SHIFT));

  // Round bookkeeping for the finishing step
  assign pool_x    = pool_q ^ x_q;
  assign next_pos  = {1'b0, pos_q} + 9'd1;
  assign round_end = (next_pos >= {1'b0, spr_q});
  assign run_inc   = (run_q == 8'hFF) ? run_q : (run_q + 8'd1);
  assign abort     = (run_inc > limit_q);

  // Sequencer: next state and datapath
  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    iter_d       = iter_q;
    ph_d         = ph_q;
    sel_b_d      = sel_b_q;
    pool_d       = pool_q;
    pos_d        = pos_q;
    run_d        = run_q;
    x_d          = x_q;
    acc_d        = acc_q;
    reseed_d     = reseed_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_pool_d   = out_pool_q;
    out_status_d = out_status_q;
    out_done_d   = out_done_q;

    case (state_q)
      jec_pkg::S_IDLE: begin
        if (in_acc) begin
          reseed_d = reseed_value_i;
          x_d      = time_after_i - time_before_i;
          iter_d   = fold_iter_q;
          if (action_i) begin
            kind_d  = jec_pkg::ST_EXTRACTED;
            state_d = jec_pkg::S_FINISH;
          end else if (time_after_i > time_before_i) begin
            kind_d  = jec_pkg::ST_FOLDED;
            state_d = (fold_iter_q == 8'd0) ? jec_pkg::S_FINISH : jec_pkg::S_PRE;
          end else begin
            kind_d  = jec_pkg::ST_SKIPPED;
            state_d = jec_pkg::S_FINISH;
          end
        end
      end

      jec_pkg::S_PRE: begin
        // leading xorshift, then start the first multiply
        x_d     = x_q ^ (x_q >> jec_pkg::PRE_SHIFT);
        ph_d    = jec_pkg::PH_LL;
        sel_b_d = 1'b0;
        state_d = jec_pkg::S_MUL;
      end

      jec_pkg::S_MUL: begin
        case (ph_q)
          jec_pkg::PH_LL: begin
            acc_d = prod;
            ph_d  = jec_pkg::PH_HL;
          end
          jec_pkg::PH_HL: begin
            acc_d = {p_hi, acc_q[31:0]};
            ph_d  = jec_pkg::PH_LH;
          end
          default: begin
            x_d  = mixed;
            ph_d = jec_pkg::PH_LL;
            if (!sel_b_q) begin
              sel_b_d = 1'b1;
            end else begin
              sel_b_d = 1'b0;
              iter_d  = iter_q - 8'd1;
              state_d = (iter_q == 8'd1) ? jec_pkg::S_FINISH : jec_pkg::S_PRE;
            end
          end
        endcase
      end

      default: begin
        // commit state and load the result once the output slot frees up
        if (out_free) begin
          out_valid_d = 1'b1;
          out_done_d  = 1'b0;
          state_d     = jec_pkg::S_IDLE;
          case (kind_q)
            jec_pkg::ST_EXTRACTED: begin
              out_pool_d   = pool_q;
              out_status_d = jec_pkg::ST_EXTRACTED;
              pool_d       = pool_q ^ reseed_q;
            end
            jec_pkg::ST_FOLDED: begin
              pool_d       = {pool_x[63-jec_pkg::POOL_ROTATE:0],
                              pool_x[63:64-jec_pkg::POOL_ROTATE]};
              out_pool_d   = pool_d;
              out_status_d = jec_pkg::ST_FOLDED;
              run_d        = 8'd0;
              if (round_end) begin
                pos_d      = 8'd0;
                out_done_d = 1'b1;
              end else begin
                pos_d = next_pos[7:0];
              end
            end
            default: begin
              out_pool_d = pool_q;
              if (abort) begin
                out_status_d = jec_pkg::ST_ABORTED;
                pos_d        = 8'd0;
                run_d        = 8'd0;
              end else begin
                out_status_d = jec_pkg::ST_SKIPPED;
                if (round_end) begin
                  pos_d      = 8'd0;
                  run_d      = 8'd0;
                  out_done_d = 1'b1;
                end else begin
                  pos_d = next_pos[7:0];
                  run_d = run_inc;
                end
              end
            end
          endcase
        end
      end
    endcase
  end

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_iter_q <= jec_pkg::RST_FOLD_ITERATIONS;
      spr_q       <= jec_pkg::RST_SAMPLES_PER_ROUND;
      limit_q     <= jec_pkg::RST_NON_ADVANCE_LIMIT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        jec_pkg::CFG_FOLD_ITERATIONS:   fold_iter_q <= cfg_wdata_i;
        jec_pkg::CFG_SAMPLES_PER_ROUND: spr_q       <= cfg_wdata_i;
        jec_pkg::CFG_NON_ADVANCE_LIMIT: limit_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jec_pkg::S_IDLE;
      kind_q      <= jec_pkg::ST_FOLDED;
      iter_q      <= 8'd0;
      ph_q        <= jec_pkg::PH_LL;
      sel_b_q     <= 1'b0;
      pool_q      <= 64'd0;
      pos_q       <= 8'd0;
      run_q       <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      iter_q      <= iter_d;
      ph_q        <= ph_d;
      sel_b_q     <= sel_b_d;
      pool_q      <= pool_d;
      pos_q       <= pos_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Update payload registers
  always_ff @(posedge clk_i) begin
    x_q          <= x_d;
    acc_q        <= acc_d;
    reseed_q     <= reseed_d;
    out_pool_q   <= out_pool_d;
    out_status_q <= out_status_d;
    out_done_q   <= out_done_d;
  end

  // Assertions
  `JEC_ASSERT(a_load_from_finish, $rose(out_valid_q) |-> $past(state_q == jec_pkg::S_FINISH), "result loaded outside finish step")
  `JEC_ASSERT(a_mul_has_work, (state_q == jec_pkg::S_MUL) |-> (iter_q != 8'd0), "multiply running with no iterations left")
  `JEC_ASSERT(a_phase_legal, (state_q == jec_pkg::S_MUL) |-> (ph_q != 2'd3), "illegal multiplier phase")
  `JEC_ASSERT_NEXT(a_accept_busy, in_valid_i && !in_stall_o, in_stall_o, "item accepted without going busy")
  `JEC_ASSERT(a_done_status, (out_valid_q && out_done_q) |-> (out_status_q == jec_pkg::ST_FOLDED || out_status_q == jec_pkg::ST_SKIPPED), "round done flagged on extract or abort")

endmodule
